[sv/pke_pkg.sv]
// Package with the types, constants and helper functions of the paired k-mer encoder.
`default_nettype none
package pke_pkg;

	localparam int MAX_KMER = 14;
	localparam int SYM_W    = 4;
	localparam int KMER_W   = SYM_W * MAX_KMER;
	localparam int FIX_W    = SYM_W * (MAX_KMER - 1);
	localparam int WORD_W   = FIX_W + 10;
	localparam int K_W      = 4;

	localparam logic [K_W-1:0] KLEN_RESET = 4'd5;
	localparam logic [K_W-1:0] KLEN_MAX   = 4'(MAX_KMER);

	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UC = 8'h43;
	localparam logic [7:0] CH_UG = 8'h47;
	localparam logic [7:0] CH_UT = 8'h54;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LC = 8'h63;
	localparam logic [7:0] CH_LG = 8'h67;
	localparam logic [7:0] CH_LT = 8'h74;

	typedef struct packed {
		logic [7:0] first_base;
		logic [7:0] second_base;
		logic       new_read;
	} pke_in_t;

	typedef struct packed {
		logic [WORD_W-1:0] record_word;
		logic              last_of_pair;
	} pke_out_t;

	typedef struct packed {
		logic [KMER_W-1:0] kmer;
		logic [K_W-1:0]    k;
		logic              emit;
	} pke_stage_t;

	// Bit 2 flags a byte that is not a base; bits 1:0 hold the base code.
	function automatic logic [2:0] base_code(input logic [7:0] ch);
		logic [2:0] r;
		case (ch)
			CH_UA, CH_LA: r = 3'b000;
			CH_UC, CH_LC: r = 3'b001;
			CH_UG, CH_LG: r = 3'b010;
			CH_UT, CH_LT: r = 3'b011;
			default:      r = 3'b100;
		endcase
		return r;
	endfunction

	// Mask that keeps the low n symbols of a k-mer.
	function automatic logic [KMER_W-1:0] sym_mask(input logic [K_W-1:0] n);
		logic [KMER_W-1:0] m;
		m = '0;
		for (int i = 0; i < MAX_KMER; i++) begin
			if (4'(i) < n) begin
				m[i*SYM_W +: SYM_W] = {SYM_W{1'b1}};
			end
		end
		return m;
	endfunction

endpackage
`default_nettype wire

[sv/pke_kmer_update.sv]
// Rolling k-mer state update and the stage register that follows it.
`default_nettype none
module pke_kmer_update (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [pke_pkg::K_W-1:0] kmer_length,
	input  wire logic                  pair_valid,
	output logic                       pair_stall,
	input  wire pke_pkg::pke_in_t      pair_data,
	output logic                       s1_valid,
	input  wire logic                  s1_ready,
	output pke_pkg::pke_stage_t        s1_data
);

	logic [pke_pkg::KMER_W-1:0] kmer_q;
	logic [pke_pkg::K_W-1:0]    fill_q;
	logic                       s1_valid_q;
	pke_pkg::pke_stage_t        stage_s1;

	logic [pke_pkg::K_W-1:0]    eff_k;
	logic [pke_pkg::KMER_W-1:0] kmer_cur;
	logic [pke_pkg::K_W-1:0]    fill_cur;
	logic [2:0]                 code1;
	logic [2:0]                 code2;
	logic                       pair_ok;
	logic [pke_pkg::KMER_W-1:0] kmer_next;
	logic [pke_pkg::K_W:0]      fill_inc;
	logic [pke_pkg::K_W-1:0]    fill_next;
	logic                       emit;
	logic                       in_fire;
	logic                       s1_take;

	always_comb begin
		if (kmer_length == '0) begin
			eff_k = 4'd1;
		end else if (kmer_length > pke_pkg::KLEN_MAX) begin
			eff_k = pke_pkg::KLEN_MAX;
		end else begin
			eff_k = kmer_length;
		end
	end

	always_comb begin
		kmer_cur  = pair_data.new_read ? '0 : kmer_q;
		fill_cur  = pair_data.new_read ? '0 : fill_q;
		code1     = pke_pkg::base_code(pair_data.first_base);
		code2     = pke_pkg::base_code(pair_data.second_base);
		pair_ok   = !code1[2] && !code2[2];
		kmer_next = {kmer_cur[pke_pkg::KMER_W-pke_pkg::SYM_W-1:0], code2[1:0], code1[1:0]}
			& pke_pkg::sym_mask(eff_k);
		fill_inc  = {1'b0, fill_cur} + 5'd1;
		fill_next = (fill_inc > {1'b0, eff_k}) ? eff_k : fill_inc[pke_pkg::K_W-1:0];
		emit      = pair_ok && (fill_next == eff_k);
	end

	assign s1_take    = s1_valid_q && s1_ready;
	assign pair_stall = s1_valid_q && !s1_ready;
	assign in_fire    = pair_valid && !pair_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_q     <= '0;
			fill_q     <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				kmer_q     <= pair_ok ? kmer_next : '0;
				fill_q     <= pair_ok ? fill_next : '0;
				s1_valid_q <= 1'b1;
			end else if (s1_take) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			stage_s1.kmer <= kmer_next;
			stage_s1.k    <= eff_k;
			stage_s1.emit <= emit;
		end
	end

	assign s1_valid = s1_valid_q;
	assign s1_data  = stage_s1;

	a_empty_fill_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == '0 |-> kmer_q == '0)
		else $error("k-mer register holds symbols while the fill count is zero");

	a_bad_pair_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !pair_ok |=> s1_valid_q && !stage_s1.emit)
		else $error("a pair with an invalid base was marked to emit");

	a_stage_k_legal: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> stage_s1.k != '0 && stage_s1.k <= pke_pkg::KLEN_MAX)
		else $error("stage carries an out-of-range k-mer length");

endmodule
`default_nettype wire

[sv/pke_word_out.sv]
// Forms the prefix and suffix words of a full k-mer and sends them as two beats.
`default_nettype none
module pke_word_out (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s1_valid,
	output logic                     s1_ready,
	input  wire pke_pkg::pke_stage_t s1_data,
	output logic                     word_valid,
	input  wire logic                word_stall,
	output pke_pkg::pke_out_t        word_data
);

	logic                       out_valid_q;
	logic                       phase_q;
	logic [pke_pkg::WORD_W-1:0] word0_q;
	logic [pke_pkg::WORD_W-1:0] word1_q;

	logic [pke_pkg::KMER_W-1:0] suffix;
	logic [pke_pkg::SYM_W-1:0]  oldest;
	logic [pke_pkg::K_W-1:0]    k_less;
	logic [pke_pkg::WORD_W-1:0] w0;
	logic [pke_pkg::WORD_W-1:0] w1;
	logic                       fire;
	logic                       load;

	always_comb begin
		k_less = s1_data.k - 4'd1;
		suffix = s1_data.kmer & pke_pkg::sym_mask(k_less);
		oldest = '0;
		for (int i = 0; i < pke_pkg::MAX_KMER; i++) begin
			if (4'(i) == k_less) begin
				oldest = s1_data.kmer[i*pke_pkg::SYM_W +: pke_pkg::SYM_W];
			end
		end
		w0 = {s1_data.kmer[pke_pkg::KMER_W-1:pke_pkg::SYM_W], 1'b0,
			s1_data.kmer[pke_pkg::SYM_W-1:0], 5'b0};
		w1 = {suffix[pke_pkg::FIX_W-1:0], 1'b1, oldest, 5'b0};
	end

	assign fire     = out_valid_q && !word_stall;
	assign s1_ready = !out_valid_q || (fire && phase_q);
	assign load     = s1_valid && s1_ready && s1_data.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= 1'b0;
			end else if (fire) begin
				if (phase_q) begin
					out_valid_q <= 1'b0;
					phase_q     <= 1'b0;
				end else begin
					phase_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word0_q <= w0;
			word1_q <= w1;
		end
	end

	assign word_valid             = out_valid_q;
	assign word_data.record_word  = phase_q ? word1_q : word0_q;
	assign word_data.last_of_pair = phase_q;

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !phase_q |=> out_valid_q && phase_q)
		else $error("the suffix word did not follow the prefix word");

	a_load_starts_pair: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q && !phase_q)
		else $error("a new k-mer did not start with its prefix word");

	a_phase_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> out_valid_q)
		else $error("second-word phase set with no word pending");

endmodule
`default_nettype wire

[sv/paired_kmer_bit_encoder.sv]
// Top level of the paired k-mer bit encoder.
// Each accepted base pair is decoded and shifted into the rolling k-mer register in the cycle
// it is taken, or clears that register if it holds an invalid base; once kmer_length symbols
// are present the pair yields two beats on the word channel, the prefix word and then the
// suffix word with last_of_pair set. A pair passes through the stage register and then the
// word registers to its first beat. The word channel sends one beat per cycle unless stalled;
// with full k-mers a pair is taken only as the last suffix word leaves, else one per cycle
// while no word waits. kmer_length resets to 5 and may be written only while idle.
`default_nettype none
module paired_kmer_bit_encoder (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [pke_pkg::K_W-1:0] cfg_data,
	input  wire logic                 pair_valid,
	output logic                      pair_stall,
	input  wire pke_pkg::pke_in_t     pair_data,
	output logic                      word_valid,
	input  wire logic                 word_stall,
	output pke_pkg::pke_out_t         word_data
);

	logic [pke_pkg::K_W-1:0] kmer_length_q;
	logic                    s1_valid;
	logic                    s1_ready;
	pke_pkg::pke_stage_t     s1_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= pke_pkg::KLEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			kmer_length_q <= cfg_data;
		end
	end

	pke_kmer_update u_update (
		.clk         (clk),
		.arst_n      (arst_n),
		.kmer_length (kmer_length_q),
		.pair_valid  (pair_valid),
		.pair_stall  (pair_stall),
		.pair_data   (pair_data),
		.s1_valid    (s1_valid),
		.s1_ready    (s1_ready),
		.s1_data     (s1_data)
	);

	pke_word_out u_word_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.s1_valid   (s1_valid),
		.s1_ready   (s1_ready),
		.s1_data    (s1_data),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word_data  (word_data)
	);

endmodule
`default_nettype wire
